// ===== sv/ray_sph_pkg.sv =====
`default_nettype none
package ray_sph_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int GUARD_BITS    = 8;
    localparam int S_DATA_W      = 320;
    localparam int M_DATA_W      = 192;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam int T_W           = 31;
    localparam int NRM_W         = 18;
    localparam int IDX_W         = 6;

    localparam logic [T_W-1:0] T_MIN_RESET = T_W'(((1 << FRAC_BITS) + 500) / 1000);
    localparam logic [T_W-1:0] T_FAR_RESET = {T_W{1'b1}};

    localparam logic [5:0] SQRT_DISC_ITERS = 6'd58;
    localparam logic [5:0] SQRT_LEN_ITERS  = 6'd35;
    localparam logic [5:0] DIV_T_ITERS     = 6'd31;
    localparam logic [5:0] DIV_N_ITERS     = 6'd17;

    localparam logic [3:0] QUAD_LAST_STEP = 4'd9;
    localparam logic [3:0] DISC_LAST_STEP = 4'd7;
    localparam logic [3:0] VEC_LAST_STEP  = 4'd2;

    localparam logic [0:0] REG_T_MIN = 1'b0;
    localparam logic [0:0] REG_T_FAR = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OC,
        ST_MUL,
        ST_ACC,
        ST_DCHK,
        ST_SQRT,
        ST_ROOT,
        ST_DIV,
        ST_TCHK,
        ST_NSET,
        ST_NSTO,
        ST_COMMIT,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        PH_QUAD,
        PH_DISC,
        PH_POINT,
        PH_LEN,
        PH_DOT
    } phase_t;

    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        logic signed [31:0] res;
        if (v > 51'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -51'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== sv/ray_sphere_closest_hit_unit.sv =====
// Closest-hit search of one ray against a stream of spheres, signed Q16.16.
// Input words arrive on s_tvalid/s_tready/s_tdata, one ray and one sphere per
// word; s_tlast marks the last sphere of a ray. Only that word produces a
// result word on m_tvalid/m_tready/m_tdata, with m_tuser carrying the hit flag.
// t_min and t_far are written over the APB port (byte addresses 0 and 4).
// One word is processed at a time by a sequencer around one shared 33x33
// multiplier, one shift-subtract square root unit and one restoring divider.
// A word stops after the quadratic terms when the squared direction length is
// zero, and after the discriminant check when no real root exists; a hit also
// runs both square roots (58 and 35 steps), the distance division (31 steps,
// twice if the near root is rejected) and three 17-step normal divisions.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register; the next word is accepted while it
// waits, and the sequencer holds at the end of a last word until the earlier
// result is taken. Reset restores t_min to 0.001 and t_far to saturated
// infinity, drops any pending result and opens a fresh ray.
`default_nettype none
module ray_sphere_closest_hit_unit #(
    parameter int MAX_SPHERES = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y,
    // center_z, radius
    input  logic [ray_sph_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // hit_t, point_x, point_y, point_z, normal_x, normal_y, normal_z,
    // front_face, sphere_index, zero pad
    output logic [ray_sph_pkg::M_DATA_W-1:0]      m_tdata,
    // any_hit
    output logic [0:0]                            m_tuser,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ray_sph_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ray_sph_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ray_sph_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                  pready
);
    import ray_sph_pkg::*;

    localparam int CNT_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_SPHERES - 1);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [T_W-1:0] t_min_reg, t_far_reg, closest_reg, closest_next;
    logic           ray_open_reg, ray_open_next;
    logic           hit_seen_reg, hit_seen_next;
    logic           best_front_reg, best_front_next;
    logic [CNT_W-1:0] best_index_reg, best_index_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [31:0]      best_point_reg [3];
    logic signed [31:0]      best_point_next [3];
    logic signed [NRM_W-1:0] best_normal_reg [3];
    logic signed [NRM_W-1:0] best_normal_next [3];

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                  m_tuser_reg, m_tuser_next;

    logic signed [31:0] o_reg [3];
    logic signed [31:0] o_next [3];
    logic signed [31:0] d_reg [3];
    logic signed [31:0] d_next [3];
    logic signed [31:0] c_reg [3];
    logic signed [31:0] c_next [3];
    logic signed [31:0] oc_reg [3];
    logic signed [31:0] oc_next [3];
    logic signed [31:0] r_reg, r_next;
    logic               last_reg, last_next;

    logic [3:0]          step_reg, step_next;
    logic signed [65:0]  prod_reg, prod_next;
    logic signed [57:0]  a_reg, a_next;
    logic signed [57:0]  hb_reg, hb_next;
    logic signed [58:0]  cc_reg, cc_next;
    logic signed [116:0] disc_reg, disc_next;
    logic [57:0]         sq_reg, sq_next;
    logic [57:0]         len_reg, len_next;
    logic [65:0]         len2_reg, len2_next;
    logic signed [50:0]  dot_reg, dot_next;
    logic                pass_reg, pass_next;
    logic                sqrt_len_reg, sqrt_len_next;
    logic                div_norm_reg, div_norm_next;
    logic [1:0]          axis_reg, axis_next;
    logic [T_W-1:0]      t_reg, t_next;
    logic signed [31:0]  p_reg [3];
    logic signed [31:0]  p_next [3];
    logic signed [32:0]  v_reg [3];
    logic signed [32:0]  v_next [3];
    logic signed [NRM_W-1:0] w_reg [3];
    logic signed [NRM_W-1:0] w_next [3];

    logic [115:0] rad_reg, rad_next;
    logic [60:0]  srem_reg, srem_next;
    logic [57:0]  root_reg, root_next;
    logic [5:0]   it_reg, it_next;

    logic [57:0] dv_rem_reg, dv_rem_next;
    logic [57:0] dv_den_reg, dv_den_next;
    logic [30:0] dv_low_reg, dv_low_next;
    logic [30:0] dv_q_reg, dv_q_next;

    logic               in_fire, cfg_we;
    logic [1:0]         ax;
    logic signed [32:0] mul_x, mul_y;
    logic [57:0]        abs_hb, abs_cc, limb_src_x, limb_src_y;
    logic [28:0]        limb_x, limb_y;
    logic [6:0]         limb_sh;
    logic signed [57:0] quad_term;
    logic [116:0]       disc_term;
    logic [60:0]        s_rem_sh, s_trial;
    logic               s_ge;
    logic [57:0]        s_root_nx;
    logic [57:0]        d_sh;
    logic               d_ge;
    logic [30:0]        d_q_nx;
    logic signed [59:0] hb_ext, sq_ext, num;
    logic               num_big;
    logic signed [50:0] pt_sum;
    logic signed [31:0] pt_sat;
    logic [32:0]        mv;
    logic [16:0]        nq, mclamp;
    logic signed [NRM_W-1:0] w_new;
    logic               front;
    logic [IDX_W-1:0]   idx_out;
    logic [M_DATA_W-1:0] out_pack;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_T_FAR) ? {1'b0, t_far_reg} : {1'b0, t_min_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_min_reg <= T_MIN_RESET;
            t_far_reg <= T_FAR_RESET;
        end else if (cfg_we) begin
            if (paddr[2] == REG_T_MIN) begin
                t_min_reg <= pwdata[T_W-1:0];
            end else begin
                t_far_reg <= pwdata[T_W-1:0];
            end
        end
    end

    // shared datapath operands
    always_comb begin
        abs_hb = hb_reg[57] ? 58'(-hb_reg) : 58'(hb_reg);
        abs_cc = cc_reg[58] ? 58'(-cc_reg) : 58'(cc_reg);
        limb_src_x = (step_reg < 4'd4) ? abs_hb : 58'(a_reg);
        limb_src_y = (step_reg < 4'd4) ? abs_hb : abs_cc;
        limb_x = step_reg[1] ? limb_src_x[57:29] : limb_src_x[28:0];
        limb_y = step_reg[0] ? limb_src_y[57:29] : limb_src_y[28:0];
        limb_sh = 7'(29 * (32'(step_reg[1]) + 32'(step_reg[0])));

        if (phase_reg == PH_QUAD) begin
            if (step_reg < 4'd3) begin
                ax = step_reg[1:0];
            end else if (step_reg < 4'd6) begin
                ax = 2'(step_reg - 4'd3);
            end else if (step_reg < 4'd9) begin
                ax = 2'(step_reg - 4'd6);
            end else begin
                ax = 2'd0;
            end
        end else begin
            ax = (step_reg > 4'd2) ? 2'd0 : step_reg[1:0];
        end

        case (phase_reg)
            PH_QUAD: begin
                if (step_reg < 4'd3) begin
                    mul_x = {d_reg[ax][31], d_reg[ax]};
                    mul_y = {d_reg[ax][31], d_reg[ax]};
                end else if (step_reg < 4'd6) begin
                    mul_x = {oc_reg[ax][31], oc_reg[ax]};
                    mul_y = {d_reg[ax][31], d_reg[ax]};
                end else if (step_reg < 4'd9) begin
                    mul_x = {oc_reg[ax][31], oc_reg[ax]};
                    mul_y = {oc_reg[ax][31], oc_reg[ax]};
                end else begin
                    mul_x = {r_reg[31], r_reg};
                    mul_y = {r_reg[31], r_reg};
                end
            end
            PH_DISC: begin
                mul_x = $signed({4'b0, limb_x});
                mul_y = $signed({4'b0, limb_y});
            end
            PH_POINT: begin
                mul_x = {d_reg[ax][31], d_reg[ax]};
                mul_y = $signed({2'b0, t_reg});
            end
            PH_LEN: begin
                mul_x = v_reg[ax];
                mul_y = v_reg[ax];
            end
            PH_DOT: begin
                mul_x = {d_reg[ax][31], d_reg[ax]};
                mul_y = {{(33-NRM_W){w_reg[ax][NRM_W-1]}}, w_reg[ax]};
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase

        quad_term = prod_reg[65:GUARD_BITS];
        disc_term = 117'(prod_reg[57:0]) << limb_sh;

        s_rem_sh  = {srem_reg[58:0], rad_reg[115:114]};
        s_trial   = {1'b0, root_reg, 2'b01};
        s_ge      = (s_rem_sh >= s_trial);
        s_root_nx = {root_reg[56:0], s_ge};

        d_sh   = {dv_rem_reg[56:0], dv_low_reg[30]};
        d_ge   = (d_sh >= dv_den_reg);
        d_q_nx = {dv_q_reg[29:0], d_ge};

        hb_ext  = {{2{hb_reg[57]}}, hb_reg};
        sq_ext  = $signed({2'b0, sq_reg});
        num     = pass_reg ? (sq_ext - hb_ext) : (-hb_ext - sq_ext);
        num_big = ({14'b0, num[58:0]} >= {a_reg[57:0], 15'b0});

        pt_sum = $signed({{19{o_reg[ax][31]}}, o_reg[ax]})
               + $signed({prod_reg[65], prod_reg[65:FRAC_BITS]});
        pt_sat = sat32(pt_sum);

        mv     = v_reg[axis_reg][32] ? 33'(-v_reg[axis_reg]) : 33'(v_reg[axis_reg]);
        nq     = dv_q_reg[16:0];
        mclamp = (nq > 17'h10000) ? 17'h10000 : nq;
        w_new  = (v_reg[axis_reg][32] ^ r_reg[31]) ? -$signed({1'b0, mclamp})
                                                   : $signed({1'b0, mclamp});
        front  = dot_reg[50];

        idx_out  = IDX_W'(best_index_reg);
        out_pack = {4'b0, idx_out, best_front_reg,
                    best_normal_reg[2], best_normal_reg[1], best_normal_reg[0],
                    best_point_reg[2], best_point_reg[1], best_point_reg[0],
                    closest_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        closest_next     = closest_reg;
        ray_open_next    = ray_open_reg;
        hit_seen_next    = hit_seen_reg;
        best_front_next  = best_front_reg;
        best_index_next  = best_index_reg;
        cnt_next         = cnt_reg;
        best_point_next  = best_point_reg;
        best_normal_next = best_normal_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        o_next           = o_reg;
        d_next           = d_reg;
        c_next           = c_reg;
        oc_next          = oc_reg;
        r_next           = r_reg;
        last_next        = last_reg;
        step_next        = step_reg;
        prod_next        = prod_reg;
        a_next           = a_reg;
        hb_next          = hb_reg;
        cc_next          = cc_reg;
        disc_next        = disc_reg;
        sq_next          = sq_reg;
        len_next         = len_reg;
        len2_next        = len2_reg;
        dot_next         = dot_reg;
        pass_next        = pass_reg;
        sqrt_len_next    = sqrt_len_reg;
        div_norm_next    = div_norm_reg;
        axis_next        = axis_reg;
        t_next           = t_reg;
        p_next           = p_reg;
        v_next           = v_reg;
        w_next           = w_reg;
        rad_next         = rad_reg;
        srem_next        = srem_reg;
        root_next        = root_reg;
        it_next          = it_reg;
        dv_rem_next      = dv_rem_reg;
        dv_den_next      = dv_den_reg;
        dv_low_next      = dv_low_reg;
        dv_q_next        = dv_q_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    for (int i = 0; i < 3; i++) begin
                        o_next[i] = s_tdata[32*i +: 32];
                        d_next[i] = s_tdata[96 + 32*i +: 32];
                        c_next[i] = s_tdata[192 + 32*i +: 32];
                    end
                    r_next    = s_tdata[288 +: 32];
                    last_next = s_tlast;
                    if (!ray_open_reg) begin
                        closest_next  = t_far_reg;
                        ray_open_next = 1'b1;
                    end
                    state_next = ST_OC;
                end
            end
            ST_OC: begin
                for (int i = 0; i < 3; i++) begin
                    oc_next[i] = sat32($signed({{19{o_reg[i][31]}}, o_reg[i]})
                                     - $signed({{19{c_reg[i][31]}}, c_reg[i]}));
                end
                a_next     = '0;
                hb_next    = '0;
                cc_next    = '0;
                phase_next = PH_QUAD;
                step_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = mul_x * mul_y;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                case (phase_reg)
                    PH_QUAD: begin
                        if (step_reg < 4'd3) begin
                            a_next = a_reg + quad_term;
                        end else if (step_reg < 4'd6) begin
                            hb_next = hb_reg + quad_term;
                        end else if (step_reg < 4'd9) begin
                            cc_next = cc_reg + {quad_term[57], quad_term};
                        end else begin
                            cc_next = cc_reg - {quad_term[57], quad_term};
                        end
                    end
                    PH_DISC: begin
                        if (step_reg < 4'd4 || cc_reg[58]) begin
                            disc_next = disc_reg + $signed(disc_term);
                        end else begin
                            disc_next = disc_reg - $signed(disc_term);
                        end
                    end
                    PH_POINT: begin
                        p_next[ax] = pt_sat;
                        v_next[ax] = $signed({pt_sat[31], pt_sat})
                                   - $signed({c_reg[ax][31], c_reg[ax]});
                    end
                    PH_LEN: begin
                        len2_next = len2_reg + 66'(prod_reg);
                    end
                    PH_DOT: begin
                        dot_next = dot_reg + prod_reg[50:0];
                    end
                    default: begin
                    end
                endcase

                step_next  = step_reg + 4'd1;
                state_next = ST_MUL;
                case (phase_reg)
                    PH_QUAD: begin
                        if (step_reg == QUAD_LAST_STEP) begin
                            step_next  = '0;
                            disc_next  = '0;
                            phase_next = PH_DISC;
                            // drop when the squared direction length a is zero
                            state_next = (a_reg == '0) ? ST_FINISH : ST_MUL;
                        end
                    end
                    PH_DISC: begin
                        if (step_reg == DISC_LAST_STEP) begin
                            state_next = ST_DCHK;
                        end
                    end
                    PH_POINT: begin
                        if (step_reg == VEC_LAST_STEP) begin
                            step_next  = '0;
                            len2_next  = '0;
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (step_reg == VEC_LAST_STEP) begin
                            rad_next      = {4'b0, len2_next, 46'b0};
                            srem_next     = '0;
                            root_next     = '0;
                            it_next       = SQRT_LEN_ITERS;
                            sqrt_len_next = 1'b1;
                            state_next    = ST_SQRT;
                        end
                    end
                    PH_DOT: begin
                        if (step_reg == VEC_LAST_STEP) begin
                            state_next = ST_COMMIT;
                        end
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_DCHK: begin
                if (disc_reg[116]) begin
                    state_next = ST_FINISH;
                end else begin
                    rad_next      = disc_reg[115:0];
                    srem_next     = '0;
                    root_next     = '0;
                    it_next       = SQRT_DISC_ITERS;
                    sqrt_len_next = 1'b0;
                    state_next    = ST_SQRT;
                end
            end
            ST_SQRT: begin
                rad_next  = {rad_reg[113:0], 2'b00};
                srem_next = s_ge ? (s_rem_sh - s_trial) : s_rem_sh;
                root_next = s_root_nx;
                it_next   = it_reg - 6'd1;
                if (it_reg == 6'd1) begin
                    if (sqrt_len_reg) begin
                        len_next   = s_root_nx;
                        axis_next  = '0;
                        state_next = ST_NSET;
                    end else begin
                        sq_next    = s_root_nx;
                        pass_next  = 1'b0;
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_ROOT: begin
                if (num[59] || num_big) begin
                    pass_next  = 1'b1;
                    state_next = pass_reg ? ST_FINISH : ST_ROOT;
                end else begin
                    dv_den_next   = a_reg;
                    dv_rem_next   = 58'(num[58:15]);
                    dv_low_next   = {num[14:0], 16'b0};
                    dv_q_next     = '0;
                    it_next       = DIV_T_ITERS;
                    div_norm_next = 1'b0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                dv_rem_next = d_ge ? (d_sh - dv_den_reg) : d_sh;
                dv_low_next = {dv_low_reg[29:0], 1'b0};
                dv_q_next   = d_q_nx;
                it_next     = it_reg - 6'd1;
                if (it_reg == 6'd1) begin
                    state_next = div_norm_reg ? ST_NSTO : ST_TCHK;
                end
            end
            ST_TCHK: begin
                if (dv_q_reg >= t_min_reg && dv_q_reg <= closest_reg) begin
                    t_next     = dv_q_reg;
                    phase_next = PH_POINT;
                    step_next  = '0;
                    state_next = ST_MUL;
                end else begin
                    pass_next  = 1'b1;
                    state_next = pass_reg ? ST_FINISH : ST_ROOT;
                end
            end
            ST_NSET: begin
                if (len_reg == '0) begin
                    w_next[axis_next] = '0;
                    w_next            = '{default: '0};
                    step_next         = '0;
                    dot_next          = '0;
                    phase_next        = PH_DOT;
                    state_next        = ST_MUL;
                end else begin
                    dv_den_next   = len_reg;
                    dv_rem_next   = 58'(mv[32:1]);
                    dv_low_next   = {mv[0], 30'b0};
                    dv_q_next     = '0;
                    it_next       = DIV_N_ITERS;
                    div_norm_next = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_NSTO: begin
                w_next[axis_reg] = w_new;
                if (axis_reg == 2'd2) begin
                    step_next  = '0;
                    dot_next   = '0;
                    phase_next = PH_DOT;
                    state_next = ST_MUL;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_NSET;
                end
            end
            ST_COMMIT: begin
                closest_next    = t_reg;
                hit_seen_next   = 1'b1;
                best_front_next = front;
                best_index_next = cnt_reg;
                for (int i = 0; i < 3; i++) begin
                    best_point_next[i]  = p_reg[i];
                    best_normal_next[i] = front ? w_reg[i] : -w_reg[i];
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!(last_reg && m_tvalid_reg && !m_tready)) begin
                    cnt_next = (cnt_reg == CNT_LAST) ? '0 : cnt_reg + 1'b1;
                    if (last_reg) begin
                        m_tvalid_next    = 1'b1;
                        m_tdata_next     = hit_seen_reg ? out_pack : '0;
                        m_tuser_next     = hit_seen_reg;
                        closest_next     = t_far_reg;
                        hit_seen_next    = 1'b0;
                        best_front_next  = 1'b0;
                        best_index_next  = '0;
                        cnt_next         = '0;
                        ray_open_next    = 1'b0;
                        best_point_next  = '{default: '0};
                        best_normal_next = '{default: '0};
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_QUAD;
            closest_reg     <= T_FAR_RESET;
            ray_open_reg    <= 1'b0;
            hit_seen_reg    <= 1'b0;
            best_front_reg  <= 1'b0;
            best_index_reg  <= '0;
            cnt_reg         <= '0;
            best_point_reg  <= '{default: '0};
            best_normal_reg <= '{default: '0};
            m_tvalid_reg    <= 1'b0;
            step_reg        <= '0;
            it_reg          <= '0;
            pass_reg        <= 1'b0;
            sqrt_len_reg    <= 1'b0;
            div_norm_reg    <= 1'b0;
            axis_reg        <= '0;
        end else begin
            phase_reg       <= phase_next;
            closest_reg     <= closest_next;
            ray_open_reg    <= ray_open_next;
            hit_seen_reg    <= hit_seen_next;
            best_front_reg  <= best_front_next;
            best_index_reg  <= best_index_next;
            cnt_reg         <= cnt_next;
            best_point_reg  <= best_point_next;
            best_normal_reg <= best_normal_next;
            m_tvalid_reg    <= m_tvalid_next;
            step_reg        <= step_next;
            it_reg          <= it_next;
            pass_reg        <= pass_next;
            sqrt_len_reg    <= sqrt_len_next;
            div_norm_reg    <= div_norm_next;
            axis_reg        <= axis_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        o_reg       <= o_next;
        d_reg       <= d_next;
        c_reg       <= c_next;
        oc_reg      <= oc_next;
        r_reg       <= r_next;
        last_reg    <= last_next;
        prod_reg    <= prod_next;
        a_reg       <= a_next;
        hb_reg      <= hb_next;
        cc_reg      <= cc_next;
        disc_reg    <= disc_next;
        sq_reg      <= sq_next;
        len_reg     <= len_next;
        len2_reg    <= len2_next;
        dot_reg     <= dot_next;
        t_reg       <= t_next;
        p_reg       <= p_next;
        v_reg       <= v_next;
        w_reg       <= w_next;
        rad_reg     <= rad_next;
        srem_reg    <= srem_next;
        root_reg    <= root_next;
        dv_rem_reg  <= dv_rem_next;
        dv_den_reg  <= dv_den_next;
        dv_low_reg  <= dv_low_next;
        dv_q_reg    <= dv_q_next;
    end

endmodule
`default_nettype wire

// ===== dv/tb_ray_sphere_closest_hit_unit.sv =====
`timescale 1ns / 100ps
module tb_ray_sphere_closest_hit_unit;
    import ray_sph_pkg::*;

    localparam int  LIMIT_CYCLES = 3000000;
    localparam int  SETTLE_CYCLES = 400;
    localparam real TCK = 10.0;

    typedef struct packed {
        logic                last;
        logic [S_DATA_W-1:0] data;
    } ray_word_t;

    typedef struct packed {
        logic                any_hit;
        logic [M_DATA_W-1:0] data;
    } hit_record_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y,
    // center_z, radius
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // hit_t, point_x, point_y, point_z, normal_x, normal_y, normal_z,
    // front_face, sphere_index, zero pad
    logic [M_DATA_W-1:0]   m_tdata;
    // any_hit
    logic [0:0]            m_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ray_sphere_closest_hit_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ray_word_t   ray_words[$];
    hit_record_t pending_records[$];
    int          mismatches = 0;
    int          idle_pct = 15;
    logic        hold_off = 1'b0;
    logic        hold_go = 1'b0;
    logic        s_took = 1'b0;
    int          cycles = 0;

    // shadow of the block
    longint      t_min_q, t_far_q, closest_t;
    logic        hit_seen, ray_open, best_front;
    longint      best_p[3], best_n[3];
    int          best_idx, sphere_cnt;

    initial begin
        forever #(TCK / 2) aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] isqrt(logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  cand;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = r | (64'd1 << b);
            sq = {64'd0, cand} * {64'd0, cand};
            if (sq <= x) r = cand;
        end
        return r;
    endfunction

    function automatic longint mag64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void open_ray_state();
        hit_seen = 1'b0;
        ray_open = 1'b0;
        best_front = 1'b0;
        best_idx = 0;
        sphere_cnt = 0;
        closest_t = t_far_q;
        for (int i = 0; i < 3; i++) begin
            best_p[i] = 0;
            best_n[i] = 0;
        end
    endfunction

    function automatic void trace_sphere(ray_word_t w);
        longint o[3], d[3], c[3], p[3], outw[3];
        longint r, a, hb, occ, cc, oc, sq, num, t, dotv, len, m, v;
        logic signed [129:0] hbw, aw, ccw, disc;
        logic [127:0] q, len2;
        logic found, front;
        hit_record_t rec;
        for (int i = 0; i < 3; i++) begin
            o[i] = longint'($signed(w.data[32*i +: 32]));
            d[i] = longint'($signed(w.data[32*(3+i) +: 32]));
            c[i] = longint'($signed(w.data[32*(6+i) +: 32]));
        end
        r = longint'($signed(w.data[32*9 +: 32]));
        if (!ray_open) begin
            closest_t = t_far_q;
            ray_open = 1'b1;
        end
        a = 0; hb = 0; occ = 0; found = 1'b0; t = 0; front = 1'b0;
        for (int i = 0; i < 3; i++) begin
            oc = clamp32(o[i] - c[i]);
            a += (d[i] * d[i]) >>> GUARD_BITS;
            hb += (oc * d[i]) >>> GUARD_BITS;
            occ += (oc * oc) >>> GUARD_BITS;
        end
        cc = occ - ((r * r) >>> GUARD_BITS);
        hbw = 130'(hb); aw = 130'(a); ccw = 130'(cc);
        disc = hbw * hbw - aw * ccw;
        if (a > 0 && disc >= 0) begin
            sq = longint'(isqrt(disc[127:0]));
            for (int pass = 0; pass < 2 && !found; pass++) begin
                num = pass ? -hb + sq : -hb - sq;
                if (num >= 0) begin
                    q = ({64'd0, num} << FRAC_BITS) / {64'd0, a};
                    if (q >= t_min_q && q <= closest_t) begin
                        t = longint'(q[63:0]);
                        found = 1'b1;
                    end
                end
            end
        end
        if (found) begin
            len2 = '0;
            for (int i = 0; i < 3; i++) begin
                p[i] = clamp32(o[i] + ((d[i] * t) >>> FRAC_BITS));
                m = mag64(p[i] - c[i]);
                len2 += {64'd0, m} * {64'd0, m};
            end
            len = longint'(isqrt(len2));
            dotv = 0;
            for (int i = 0; i < 3; i++) begin
                v = p[i] - c[i];
                if (len == 0) begin
                    outw[i] = 0;
                end else begin
                    m = (mag64(v) << FRAC_BITS) / len;
                    if (m > (64'sd1 << FRAC_BITS)) m = 64'sd1 << FRAC_BITS;
                    outw[i] = v < 0 ? -m : m;
                    if (r < 0) outw[i] = -outw[i];
                end
                dotv += d[i] * outw[i];
            end
            front = dotv < 0;
            closest_t = t;
            hit_seen = 1'b1;
            best_front = front;
            best_idx = sphere_cnt;
            for (int i = 0; i < 3; i++) begin
                best_p[i] = p[i];
                best_n[i] = front ? outw[i] : -outw[i];
            end
        end
        sphere_cnt = (sphere_cnt + 1 >= 64) ? 0 : sphere_cnt + 1;
        if (w.last) begin
            rec.any_hit = hit_seen;
            if (hit_seen) begin
                rec.data = {4'b0, best_idx[5:0], best_front,
                            best_n[2][17:0], best_n[1][17:0], best_n[0][17:0],
                            best_p[2][31:0], best_p[1][31:0], best_p[0][31:0],
                            closest_t[30:0]};
            end else begin
                rec.data = '0;
            end
            pending_records.insert(pending_records.size(), rec);
            open_ray_state();
        end
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        mismatches++;
    endtask

    // sender
    always @(posedge aclk) s_took <= aresetn && s_tvalid && s_tready;

    always @(negedge aclk) begin
        if (s_took) begin
            trace_sphere(ray_words.pop_front());
        end
        if (s_tvalid && !s_took) begin
            s_tvalid <= 1'b1;
        end else if (ray_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
            s_tvalid <= 1'b1;
            s_tdata <= ray_words[0].data;
            s_tlast <= ray_words[0].last;
        end else begin
            s_tvalid <= 1'b0;
        end
        m_tready <= aresetn && !hold_off && ($urandom_range(99) >= idle_pct);
    end

    // result checker
    always @(posedge aclk) begin
        hit_record_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_records.size() == 0) begin
                report("unexpected word", m_tdata[63:0], 64'd0);
            end else begin
                want = pending_records.pop_front();
                if (m_tuser[0] !== want.any_hit)
                    report("any_hit", 64'(m_tuser), 64'(want.any_hit));
                if (m_tdata[30:0] !== want.data[30:0])
                    report("hit_t", 64'(m_tdata[30:0]), 64'(want.data[30:0]));
                if (m_tdata[62:31] !== want.data[62:31])
                    report("point_x", 64'(m_tdata[62:31]), 64'(want.data[62:31]));
                if (m_tdata[94:63] !== want.data[94:63])
                    report("point_y", 64'(m_tdata[94:63]), 64'(want.data[94:63]));
                if (m_tdata[126:95] !== want.data[126:95])
                    report("point_z", 64'(m_tdata[126:95]), 64'(want.data[126:95]));
                if (m_tdata[144:127] !== want.data[144:127])
                    report("normal_x", 64'(m_tdata[144:127]), 64'(want.data[144:127]));
                if (m_tdata[162:145] !== want.data[162:145])
                    report("normal_y", 64'(m_tdata[162:145]), 64'(want.data[162:145]));
                if (m_tdata[180:163] !== want.data[180:163])
                    report("normal_z", 64'(m_tdata[180:163]), 64'(want.data[180:163]));
                if (m_tdata[181] !== want.data[181])
                    report("front_face", 64'(m_tdata[181]), 64'(want.data[181]));
                if (m_tdata[187:182] !== want.data[187:182])
                    report("sphere_index", 64'(m_tdata[187:182]),
                           64'(want.data[187:182]));
            end
        end
    end

    // long receiver hold-off
    initial begin
        @(posedge hold_go);
        @(negedge aclk);
        hold_off = 1'b1;
        repeat (4000) @(posedge aclk);
        @(negedge aclk);
        hold_off = 1'b0;
    end

    function automatic int unit(int x);
        return x * 65536;
    endfunction

    function automatic int spread(int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    function automatic void add_word(int ox, int oy, int oz, int dx, int dy, int dz,
                                     int cx, int cy, int cz, int r, logic last);
        ray_word_t w;
        w.last = last;
        w.data = {r, cz, cy, cx, dz, dy, dx, oz, oy, ox};
        ray_words.insert(ray_words.size(), w);
    endfunction

    function automatic void add_ray(int n);
        int o[3], d[3], c[3];
        int r, k;
        for (int s = 0; s < n; s++) begin
            if ($urandom_range(99) < 12) begin
                add_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, s == n - 1);
            end else begin
                k = $urandom_range(unit(8), unit(1) / 4);
                for (int i = 0; i < 3; i++) begin
                    if (s == 0) begin
                        o[i] = spread(unit(10));
                        d[i] = ($urandom_range(99) < 3) ? 0 : spread(unit(2));
                    end
                    c[i] = int'(clamp32(longint'(o[i])
                                        + ((longint'(d[i]) * k) >>> FRAC_BITS)
                                        + spread(unit(1))));
                end
                r = $urandom_range(unit(3), unit(1) / 4);
                if ($urandom_range(99) < 15) r = -r;
                add_word(o[0], o[1], o[2], d[0], d[1], d[2], c[0], c[1], c[2], r,
                         s == n - 1);
            end
        end
    endfunction

    task automatic apb_write(logic [0:0] reg_sel, logic [30:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {reg_sel, 2'b00};
        pwdata <= {1'b0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == REG_T_MIN) t_min_q = longint'(value);
        else t_far_q = longint'(value);
    endtask

    task automatic settle();
        while (ray_words.size() > 0 || pending_records.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase(int count, int max_len);
        int start;
        start = ray_words.size();
        while (ray_words.size() - start < count) add_ray($urandom_range(max_len, 1));
        settle();
    endtask

    initial begin
        t_min_q = longint'(T_MIN_RESET);
        t_far_q = longint'(T_FAR_RESET);
        open_ray_state();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: field extremes, degenerate directions, misses, roots, shells
        add_word(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1);
        add_word(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1);
        add_word(0, 0, 0, 0, 0, 0, unit(1), 0, 0, unit(5), 1);
        add_word(0, 0, 0, 1, 0, 0, unit(1), 0, 0, unit(5), 1);
        add_word(0, 0, 0, 0, 0, unit(1), unit(5), 0, unit(5), unit(1), 1);
        add_word(0, 0, 0, 0, 0, unit(1), 0, 0, unit(5), unit(1), 0);
        add_word(0, 0, 0, 0, 0, unit(1), 0, 0, unit(5), -unit(1), 0);
        add_word(0, 0, 0, 0, 0, unit(1), 0, 0, -unit(5), unit(1), 1);
        add_word(0, 0, 0, unit(1), 0, 0, 0, 0, 0, unit(2), 1);
        add_word(0, 0, -unit(5), 0, 0, unit(1), 0, 0, 0, 0, 1);
        add_word(0, 0, 0, 0, 0, 16, 0, 0, unit(100), unit(1), 1);
        add_word(unit(3), -unit(2), unit(1), -unit(1), unit(1), unit(2),
                 -unit(2), unit(4), unit(8), unit(3), 0);
        add_word(unit(3), -unit(2), unit(1), -unit(1), unit(1), unit(2),
                 unit(1), unit(1), unit(6), -unit(2), 1);
        settle();

        apb_write(REG_T_MIN, 31'd0);
        apb_write(REG_T_FAR, 31'h7FFFFFFF);
        hold_go = 1'b1;
        random_phase(300, 8);
        idle_pct = 0;
        random_phase(150, 8);
        idle_pct = 15;

        // leave a ray open across a t_far change
        add_ray(3);
        void'(ray_words.pop_back());
        add_word(0, 0, 0, 0, 0, unit(1), 0, 0, unit(5), unit(1), 0);
        settle();
        apb_write(REG_T_FAR, 31'd0);
        add_word(0, 0, 0, 0, 0, unit(1), 0, 0, unit(9), unit(1), 1);
        settle();

        apb_write(REG_T_MIN, 31'h7FFFFFFF);
        random_phase(50, 6);
        apb_write(REG_T_MIN, 31'd0);
        random_phase(40, 6);

        apb_write(REG_T_MIN, 31'($urandom_range(unit(2))));
        apb_write(REG_T_FAR, 31'($urandom_range(unit(12), unit(3))));
        add_ray(70);
        random_phase(250, 8);

        apb_write(REG_T_MIN, T_MIN_RESET);
        apb_write(REG_T_FAR, T_FAR_RESET);
        random_phase(400, 8);

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ray_sph_pkg.sv
sv/ray_sphere_closest_hit_unit.sv
dv/tb_ray_sphere_closest_hit_unit.sv
